// File: rtl/core/mts_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Min tracking stack package
// Sizes, request and status codes, and the per-cell entry types.
// ----------------------------------------------------------------------------
package mts_pkg;

  localparam int STACK_DEPTH = 64;
  localparam int WORD_W      = 32;
  localparam int COUNT_W     = $clog2(STACK_DEPTH + 1);

  localparam logic [COUNT_W-1:0] FULL_COUNT = COUNT_W'(STACK_DEPTH);

  localparam logic [1:0] KIND_PUSH = 2'd0;
  localparam logic [1:0] KIND_POP  = 2'd1;
  localparam logic [1:0] KIND_PEEK = 2'd2;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  localparam logic signed [WORD_W-1:0] NONE_WORD = '1;

  // value held at one level and the minimum of that level and all below it
  typedef struct packed {
    logic signed [WORD_W-1:0] value;
    logic signed [WORD_W-1:0] minv;
  } entry_t;

  typedef struct packed {
    logic push;
    logic pop;
  } shift_ctl_t;

endpackage
`default_nettype wire

// File: rtl/core/mts_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Min tracking stack cell
// One stack level: takes the entry above on push, the entry below on pop.
// ----------------------------------------------------------------------------
module mts_cell
  import mts_pkg::*;
(
  input  wire logic       clk,
  input  wire shift_ctl_t ctl,
  input  wire entry_t     above,
  input  wire entry_t     below,
  output entry_t          held
);

  always_ff @(posedge clk) begin
    if (ctl.push) begin
      held <= above;
    end else if (ctl.pop) begin
      held <= below;
    end
  end

endmodule
`default_nettype wire

// File: rtl/core/min_tracking_stack.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Min tracking stack
// Stack of signed words that also reports the minimum of its contents.
// ----------------------------------------------------------------------------
// Requests enter on the s_ channel: s_tuser carries the kind (push, pop,
// peek; code 3 acts as a peek) and s_tdata the value to push.
// Each request gives exactly one result on the m_ channel: m_tdata holds
// the top and the minimum after the operation (-1 and -1 when empty) and
// m_tuser the status (ok, empty, full).
// The stack is a row of STACK_DEPTH cells; every cell keeps its value and
// the running minimum of itself and all cells below, so push and pop are a
// shift of the whole row.
// The result is registered and appears in the cycle after the request is accepted.
// Throughput: one request per cycle; a result register sits between the
// sides, so a request is accepted while m_tready is low only if the result
// register is empty. When the receiver stalls, the result holds and
// s_tready drops until it is taken.
// Reset empties the stack and the result register; cell contents are not
// cleared, as nothing reads a level above the count.
// ----------------------------------------------------------------------------
module min_tracking_stack
  import mts_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [31:0] s_tdata,  // [31:0] push_value
  input  wire logic [1:0]  s_tuser,  // [1:0] kind
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [63:0]      m_tdata,  // [31:0] top_value, [63:32] min_value
  output logic [1:0]       m_tuser   // [1:0] status
);

  logic [COUNT_W-1:0] count;
  logic [COUNT_W-1:0] count_next;
  entry_t             cells [STACK_DEPTH];
  entry_t             fresh;
  shift_ctl_t         ctl;
  logic               accept;
  logic               is_full;
  logic               is_empty;
  logic signed [WORD_W-1:0] push_value;
  logic [1:0]         kind;
  logic signed [WORD_W-1:0] top_next;
  logic signed [WORD_W-1:0] min_next;
  logic [1:0]         status_next;

  assign push_value = s_tdata;
  assign kind       = s_tuser;
  assign s_tready   = !m_tvalid || m_tready;
  assign accept     = s_tvalid && s_tready;
  assign is_full    = (count == FULL_COUNT);
  assign is_empty   = (count == '0);

  assign ctl.push = accept && (kind == KIND_PUSH) && !is_full;
  assign ctl.pop  = accept && (kind == KIND_POP) && !is_empty;

  always_comb begin
    fresh.value = push_value;
    if (is_empty || (push_value <= cells[0].minv)) begin
      fresh.minv = push_value;
    end else begin
      fresh.minv = cells[0].minv;
    end
  end

  for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
    entry_t above;
    entry_t below;
    if (i == 0) begin : g_head
      assign above = fresh;
    end else begin : g_body
      assign above = cells[i-1];
    end
    if (i == STACK_DEPTH - 1) begin : g_tail
      assign below = cells[i];
    end else begin : g_link
      assign below = cells[i+1];
    end
    mts_cell u_cell (
      .clk   (clk),
      .ctl   (ctl),
      .above (above),
      .below (below),
      .held  (cells[i])
    );
  end

  always_comb begin
    count_next = count;
    if (ctl.push) begin
      count_next = count + 1'b1;
    end else if (ctl.pop) begin
      count_next = count - 1'b1;
    end
  end

  always_comb begin
    top_next    = cells[0].value;
    min_next    = cells[0].minv;
    status_next = ST_OK;
    case (kind)
      KIND_PUSH: begin
        if (is_full) begin
          status_next = ST_FULL;
        end else begin
          top_next = fresh.value;
          min_next = fresh.minv;
        end
      end
      KIND_POP: begin
        if (is_empty) begin
          top_next    = NONE_WORD;
          min_next    = NONE_WORD;
          status_next = ST_EMPTY;
        end else if (count == COUNT_W'(1)) begin
          top_next = NONE_WORD;
          min_next = NONE_WORD;
        end else begin
          top_next = cells[1].value;
          min_next = cells[1].minv;
        end
      end
      default: begin
        if (is_empty) begin
          top_next    = NONE_WORD;
          min_next    = NONE_WORD;
          status_next = ST_EMPTY;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      count <= count_next;
      if (accept) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      m_tdata <= {min_next, top_next};
      m_tuser <= status_next;
    end
  end

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= FULL_COUNT)
    else $error("stack count beyond depth");

  a_full_status: assert property (@(posedge clk) disable iff (rst)
    accept && (kind == KIND_PUSH) && is_full |=> m_tvalid && (m_tuser == ST_FULL)
      && (count == FULL_COUNT))
    else $error("push on full stack not refused");

  a_empty_status: assert property (@(posedge clk) disable iff (rst)
    accept && (kind != KIND_PUSH) && is_empty |=> m_tvalid && (m_tuser == ST_EMPTY)
      && (count == '0))
    else $error("request on empty stack not reported");

  a_min_bound: assert property (@(posedge clk) disable iff (rst)
    !is_empty |-> cells[0].minv <= cells[0].value)
    else $error("minimum above top value");
`endif

endmodule
`default_nettype wire
